### hw/rtl/mpd_pkg.sv
// shared types and constants for the publish frame decoder
package mpd_pkg;

  localparam int FIELD_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TOPIC_CAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_CAP = 1'd1;

  localparam logic [FIELD_W-1:0] TOPIC_CAP_RESET = 16'd96;
  localparam logic [FIELD_W-1:0] PAYLOAD_CAP_RESET = 16'd320;

  localparam logic [3:0] TYPE_PUBLISH = 4'h3;
  localparam logic [2:0] MAX_LEN_DIGITS = 3'd4;
  localparam logic [2:0] MIN_FRAME_BYTES = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PKTID,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_NOT_PUBLISH,
    ST_BAD_LEN_CODE,
    ST_LEN_RANGE,
    ST_BAD_TOPIC,
    ST_NO_PKTID,
    ST_PAYLOAD_LONG
  } status_t;

  typedef enum logic [1:0] {
    KIND_TOPIC,
    KIND_PAYLOAD,
    KIND_VERDICT
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         byte_value;
    status_t            status;
    logic [FIELD_W-1:0] topic_length;
    logic [FIELD_W-1:0] payload_length;
    logic [1:0]         qos_level;
    logic               last;
  } res_t;

endpackage

### hw/rtl/mpd_ifs.sv
// stream channel interfaces for packet bytes in and decoded words out
interface mpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpd_tx_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [2:0]  status;
  logic [15:0] topic_length;
  logic [15:0] payload_length;
  logic [1:0]  qos_level;
  logic        last;

  modport source (
    output valid, output kind, output byte_value, output status,
    output topic_length, output payload_length, output qos_level, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input byte_value, input status,
    input topic_length, input payload_length, input qos_level, input last,
    output ready
  );
endinterface

### hw/rtl/mqtt_publish_deframer_core.sv
// the result words of an accepted byte are written into the result queue, whose head drives tx
// throughput: one byte per cycle; each topic or payload byte yields a word, the last
// byte a verdict word too; rx.ready drops while the four-word queue lacks two free slots
// reset: clears the parse state and the result queue, capacities return to 96 and 320
// top level of the publish frame decoder
module mqtt_publish_deframer_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  mpd_rx_if.sink                          rx,
  mpd_tx_if.source                        tx,
  input  logic                            cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [mpd_pkg::FIELD_W-1:0] topic_cap;
  logic [mpd_pkg::FIELD_W-1:0] payload_cap;
  logic                        accept;
  logic                        space_ok;
  logic                        q_valid;
  logic                        pop;
  logic [1:0]                  push_n;
  mpd_pkg::res_t               item0;
  mpd_pkg::res_t               item1;
  mpd_pkg::res_t               head;

  assign rx.ready = space_ok;
  assign accept   = rx.valid && space_ok;
  assign pop      = q_valid && tx.ready;

  mpd_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .topic_cap   (topic_cap),
    .payload_cap (payload_cap)
  );

  mpd_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (rx.data_byte),
    .last_byte   (rx.last_byte),
    .topic_cap   (topic_cap),
    .payload_cap (payload_cap),
    .push_n      (push_n),
    .item0       (item0),
    .item1       (item1)
  );

  mpd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .item0    (item0),
    .item1    (item1),
    .pop      (pop),
    .space_ok (space_ok),
    .valid    (q_valid),
    .head     (head)
  );

  assign tx.valid          = q_valid;
  assign tx.kind           = head.kind;
  assign tx.byte_value     = head.byte_value;
  assign tx.status         = head.status;
  assign tx.topic_length   = head.topic_length;
  assign tx.payload_length = head.payload_length;
  assign tx.qos_level      = head.qos_level;
  assign tx.last           = head.last;

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> rx.valid && rx.ready)
    else $error("result word pushed without an accepted byte");

  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2 || (push_n == 2'd1 && item0.kind == mpd_pkg::KIND_VERDICT))
      |-> rx.last_byte)
    else $error("verdict word pushed on a byte that does not end the packet");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !tx.valid)
    else $error("result word present right after reset");

endmodule

### hw/rtl/mpd_parser.sv
// frame parse state and per-byte result generation
module mpd_parser #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic [mpd_pkg::FIELD_W-1:0]  topic_cap,
  input  logic [mpd_pkg::FIELD_W-1:0]  payload_cap,
  output logic [1:0]                   push_n,
  output mpd_pkg::res_t                item0,
  output mpd_pkg::res_t                item1
);

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  mpd_pkg::phase_t              phase, phase_step, phase_next;
  mpd_pkg::status_t             err_code, err_step, err_next;
  logic [CW-1:0]                bytes_seen, seen_step, seen_next;
  logic [7:0]                   header_byte, header_step, header_next;
  logic [27:0]                  rem_len, rem_step, rem_next;
  logic [2:0]                   len_digits, digits_step, digits_next;
  logic [CW-1:0]                frame_end, fe_step, fe_next;
  logic [mpd_pkg::FIELD_W-1:0]  topic_size, topic_step, topic_next;
  logic [mpd_pkg::FIELD_W-1:0]  field_count, fc_step, fc_next;

  logic [CW:0]                  next_pos;
  logic [CW:0]                  fe_ext;
  logic [CW:0]                  avail_diff;
  logic [CW-1:0]                avail;
  logic [27:0]                  digit_val;
  logic [27:0]                  rem_sum;
  logic [28:0]                  end_sum;
  logic                         end_bad;
  logic [mpd_pkg::FIELD_W-1:0]  topic_full;
  logic                         tl_bad;
  logic [mpd_pkg::FIELD_W-1:0]  fc_dec;
  logic                         pktid_bad;
  logic [mpd_pkg::FIELD_W-1:0]  plen;
  logic                         plen_bad;
  mpd_pkg::phase_t              bp_phase;
  mpd_pkg::status_t             verdict_status;
  logic                         byte_valid;
  mpd_pkg::res_t                byte_item;
  mpd_pkg::res_t                verdict_item;

  always_comb begin
    next_pos   = {1'b0, bytes_seen} + (CW+1)'(1);
    fe_ext     = {1'b0, frame_end};
    avail_diff = fe_ext - next_pos;
    avail      = (fe_ext >= next_pos) ? avail_diff[CW-1:0] : '0;
    case (len_digits)
      3'd0:    digit_val = 28'(data_byte[6:0]);
      3'd1:    digit_val = 28'(data_byte[6:0]) << 7;
      3'd2:    digit_val = 28'(data_byte[6:0]) << 14;
      3'd3:    digit_val = 28'(data_byte[6:0]) << 21;
      default: digit_val = '0;
    endcase
    rem_sum    = rem_len | digit_val;
    end_sum    = 29'(next_pos) + 29'(rem_sum);
    end_bad    = (rem_sum < 28'd2) || (end_sum > 29'(COUNT_MAX));
    topic_full = {topic_size[15:8], data_byte};
    tl_bad     = (topic_full == '0) || (topic_full >= topic_cap) ||
                 (17'(topic_full) > 17'(avail));
    fc_dec     = (field_count != '0) ? field_count - 16'd1 : '0;
    pktid_bad  = ((CW+2)'(next_pos) + (CW+2)'(2)) > (CW+2)'(frame_end);
    plen       = 16'(avail);
    plen_bad   = plen >= payload_cap;
    bp_phase   = (plen_bad || plen == '0) ? mpd_pkg::PH_DONE : mpd_pkg::PH_PAYLOAD;
  end

  // next state
  always_comb begin
    phase_step  = phase;
    err_step    = err_code;
    seen_step   = bytes_seen;
    header_step = header_byte;
    rem_step    = rem_len;
    digits_step = len_digits;
    fe_step     = frame_end;
    topic_step  = topic_size;
    fc_step     = field_count;
    if (accept) begin
      if (bytes_seen != COUNT_MAX) begin
        seen_step = bytes_seen + CW'(1);
      end
      case (phase)
        mpd_pkg::PH_HEADER: begin
          header_step = data_byte;
          if (data_byte[7:4] != mpd_pkg::TYPE_PUBLISH) begin
            err_step   = mpd_pkg::ST_NOT_PUBLISH;
            phase_step = mpd_pkg::PH_DONE;
          end else begin
            phase_step = mpd_pkg::PH_LENGTH;
          end
        end
        mpd_pkg::PH_LENGTH: begin
          if (len_digits >= mpd_pkg::MAX_LEN_DIGITS) begin
            err_step   = mpd_pkg::ST_BAD_LEN_CODE;
            phase_step = mpd_pkg::PH_DONE;
          end else begin
            rem_step    = rem_sum;
            digits_step = len_digits + 3'd1;
            if (!data_byte[7]) begin
              if (end_bad) begin
                err_step   = mpd_pkg::ST_LEN_RANGE;
                phase_step = mpd_pkg::PH_DONE;
              end else begin
                fe_step    = end_sum[CW-1:0];
                phase_step = mpd_pkg::PH_TLEN_HI;
              end
            end
          end
        end
        mpd_pkg::PH_TLEN_HI: begin
          topic_step = {data_byte, 8'h00};
          phase_step = mpd_pkg::PH_TLEN_LO;
        end
        mpd_pkg::PH_TLEN_LO: begin
          topic_step = topic_full;
          if (tl_bad) begin
            err_step   = mpd_pkg::ST_BAD_TOPIC;
            phase_step = mpd_pkg::PH_DONE;
          end else begin
            fc_step    = topic_full;
            phase_step = mpd_pkg::PH_TOPIC;
          end
        end
        mpd_pkg::PH_TOPIC: begin
          fc_step = fc_dec;
          if (fc_dec == '0) begin
            if (header_byte[2:1] != 2'd0) begin
              if (pktid_bad) begin
                err_step   = mpd_pkg::ST_NO_PKTID;
                phase_step = mpd_pkg::PH_DONE;
              end else begin
                fc_step    = 16'd2;
                phase_step = mpd_pkg::PH_PKTID;
              end
            end else begin
              fc_step    = plen;
              phase_step = bp_phase;
              if (plen_bad) begin
                err_step = mpd_pkg::ST_PAYLOAD_LONG;
              end
            end
          end
        end
        mpd_pkg::PH_PKTID: begin
          fc_step = fc_dec;
          if (fc_dec == '0) begin
            fc_step    = plen;
            phase_step = bp_phase;
            if (plen_bad) begin
              err_step = mpd_pkg::ST_PAYLOAD_LONG;
            end
          end
        end
        mpd_pkg::PH_PAYLOAD: begin
          if (next_pos >= fe_ext) begin
            phase_step = mpd_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (accept && last_byte) begin
      phase_next  = mpd_pkg::PH_HEADER;
      err_next    = mpd_pkg::ST_OK;
      seen_next   = '0;
      header_next = '0;
      rem_next    = '0;
      digits_next = '0;
      fe_next     = '0;
      topic_next  = '0;
      fc_next     = '0;
    end else begin
      phase_next  = phase_step;
      err_next    = err_step;
      seen_next   = seen_step;
      header_next = header_step;
      rem_next    = rem_step;
      digits_next = digits_step;
      fe_next     = fe_step;
      topic_next  = topic_step;
      fc_next     = fc_step;
    end
  end

  // result words
  always_comb begin
    if (seen_step < CW'(mpd_pkg::MIN_FRAME_BYTES)) begin
      verdict_status = mpd_pkg::ST_SHORT;
    end else if (err_step inside {mpd_pkg::ST_NOT_PUBLISH, mpd_pkg::ST_BAD_LEN_CODE,
                                  mpd_pkg::ST_LEN_RANGE}) begin
      verdict_status = err_step;
    end else if (phase_step == mpd_pkg::PH_LENGTH) begin
      verdict_status = mpd_pkg::ST_BAD_LEN_CODE;
    end else if (seen_step < fe_step) begin
      verdict_status = mpd_pkg::ST_LEN_RANGE;
    end else begin
      verdict_status = err_step;
    end

    byte_valid = accept &&
                 (phase == mpd_pkg::PH_TOPIC || phase == mpd_pkg::PH_PAYLOAD);

    byte_item.kind           = (phase == mpd_pkg::PH_TOPIC) ? mpd_pkg::KIND_TOPIC
                                                            : mpd_pkg::KIND_PAYLOAD;
    byte_item.byte_value     = data_byte;
    byte_item.status         = mpd_pkg::ST_OK;
    byte_item.topic_length   = '0;
    byte_item.payload_length = '0;
    byte_item.qos_level      = header_step[2:1];
    byte_item.last           = 1'b0;

    verdict_item.kind           = mpd_pkg::KIND_VERDICT;
    verdict_item.byte_value     = '0;
    verdict_item.status         = verdict_status;
    verdict_item.topic_length   = topic_step;
    verdict_item.payload_length = (verdict_status == mpd_pkg::ST_OK ||
                                   verdict_status == mpd_pkg::ST_PAYLOAD_LONG)
                                  ? fc_step : '0;
    verdict_item.qos_level      = header_step[2:1];
    verdict_item.last           = 1'b1;

    item0  = byte_valid ? byte_item : verdict_item;
    item1  = verdict_item;
    push_n = 2'(byte_valid) + 2'(accept && last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mpd_pkg::PH_HEADER;
      err_code    <= mpd_pkg::ST_OK;
      bytes_seen  <= '0;
      header_byte <= '0;
      rem_len     <= '0;
      len_digits  <= '0;
      frame_end   <= '0;
      topic_size  <= '0;
      field_count <= '0;
    end else begin
      phase       <= phase_next;
      err_code    <= err_next;
      bytes_seen  <= seen_next;
      header_byte <= header_next;
      rem_len     <= rem_next;
      len_digits  <= digits_next;
      frame_end   <= fe_next;
      topic_size  <= topic_next;
      field_count <= fc_next;
    end
  end

endmodule

### hw/rtl/mpd_out_queue.sv
// small result queue taking up to two words per cycle
module mpd_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_n,
  input  mpd_pkg::res_t item0,
  input  mpd_pkg::res_t item1,
  input  logic          pop,
  output logic          space_ok,
  output logic          valid,
  output mpd_pkg::res_t head
);

  mpd_pkg::res_t             mem [mpd_pkg::Q_DEPTH];
  logic [mpd_pkg::Q_AW-1:0]  wr_ptr, wr_ptr_next;
  logic [mpd_pkg::Q_AW-1:0]  rd_ptr, rd_ptr_next;
  logic [mpd_pkg::Q_AW:0]    count, count_next;
  logic [mpd_pkg::Q_AW-1:0]  wr_ptr_plus1;

  always_comb begin
    wr_ptr_plus1 = wr_ptr + mpd_pkg::Q_AW'(1);
    wr_ptr_next  = wr_ptr + mpd_pkg::Q_AW'(push_n);
    rd_ptr_next  = rd_ptr + mpd_pkg::Q_AW'(pop);
    count_next   = count + (mpd_pkg::Q_AW+1)'(push_n) - (mpd_pkg::Q_AW+1)'(pop);
    space_ok     = count <= (mpd_pkg::Q_AW+1)'(mpd_pkg::Q_DEPTH - 2);
    valid        = count != '0;
    head         = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= item0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_plus1] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

### hw/rtl/mpd_publish_deframer_core_top_placeholder.sv
// capacity register file for the decoder
module mpd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [mpd_pkg::FIELD_W-1:0]       topic_cap,
  output logic [mpd_pkg::FIELD_W-1:0]       payload_cap
);

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_cap   <= mpd_pkg::TOPIC_CAP_RESET;
      payload_cap <= mpd_pkg::PAYLOAD_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mpd_pkg::REG_TOPIC_CAP:   topic_cap <= cfg_data;
        mpd_pkg::REG_PAYLOAD_CAP: payload_cap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### verif/tb_mqtt_publish_deframer_core.sv
// testbench for the publish frame decoder: directed and random frames checked word by word
module tb_mqtt_publish_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_MAX = 65535;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 325;
  localparam int RANDOM_PHASES = 5;

  class publish_scoreboard;
    int unsigned       topic_cap;
    int unsigned       payload_cap;
    mpd_pkg::phase_t   phase;
    int unsigned       seen;
    int unsigned       rem_len;
    int unsigned       digits;
    int unsigned       frame_end;
    int unsigned       topic_size;
    int unsigned       field_cnt;
    logic [7:0]        hdr;
    mpd_pkg::status_t  err;
    mpd_pkg::res_t     expected_words[$];
    int unsigned       fails;
    int unsigned       checked;
    int unsigned       verdicts[8];

    function new();
      topic_cap = mpd_pkg::TOPIC_CAP_RESET;
      payload_cap = mpd_pkg::PAYLOAD_CAP_RESET;
      clear_frame();
    endfunction

    function void clear_frame();
      phase = mpd_pkg::PH_HEADER;
      seen = 0;
      rem_len = 0;
      digits = 0;
      frame_end = 0;
      topic_size = 0;
      field_cnt = 0;
      hdr = 8'h00;
      err = mpd_pkg::ST_OK;
    endfunction

    function void set_cap(logic [mpd_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
      if (idx == mpd_pkg::REG_TOPIC_CAP) begin
        topic_cap = value & 16'hFFFF;
      end else begin
        payload_cap = value & 16'hFFFF;
      end
    endfunction

    function void abort(mpd_pkg::status_t code);
      err = code;
      phase = mpd_pkg::PH_DONE;
    endfunction

    function void queue_word(mpd_pkg::kind_t k, logic [7:0] value, mpd_pkg::status_t st,
                             int unsigned tlen, int unsigned plen);
      mpd_pkg::res_t w;
      w.kind = k;
      w.byte_value = value;
      w.status = st;
      w.topic_length = 16'(tlen);
      w.payload_length = 16'(plen);
      w.qos_level = hdr[2:1];
      w.last = (k == mpd_pkg::KIND_VERDICT);
      expected_words.push_back(w);
    endfunction

    function void start_payload(int unsigned nxt);
      int unsigned plen;
      plen = (frame_end >= nxt) ? frame_end - nxt : 0;
      field_cnt = plen;
      if (plen >= payload_cap) begin
        abort(mpd_pkg::ST_PAYLOAD_LONG);
      end else if (plen == 0) begin
        phase = mpd_pkg::PH_DONE;
      end else begin
        phase = mpd_pkg::PH_PAYLOAD;
      end
    endfunction

    function void after_topic(int unsigned nxt);
      if (hdr[2:1] != 2'd0) begin
        if (nxt + 2 > frame_end) begin
          abort(mpd_pkg::ST_NO_PKTID);
        end else begin
          field_cnt = 2;
          phase = mpd_pkg::PH_PKTID;
        end
      end else begin
        start_payload(nxt);
      end
    endfunction

    function void decode_byte(logic [7:0] b, logic fin);
      int unsigned      nxt;
      int unsigned      avail;
      mpd_pkg::status_t st;
      nxt = seen + 1;
      if (seen < COUNT_MAX) seen++;
      case (phase)
        mpd_pkg::PH_HEADER: begin
          hdr = b;
          if (b[7:4] != mpd_pkg::TYPE_PUBLISH) abort(mpd_pkg::ST_NOT_PUBLISH);
          else phase = mpd_pkg::PH_LENGTH;
        end
        mpd_pkg::PH_LENGTH: begin
          if (digits >= mpd_pkg::MAX_LEN_DIGITS) begin
            abort(mpd_pkg::ST_BAD_LEN_CODE);
          end else begin
            rem_len += (32'(b[6:0]) << (7 * digits));
            digits++;
            if (!b[7]) begin
              if (rem_len < 2 || nxt + rem_len > COUNT_MAX) begin
                abort(mpd_pkg::ST_LEN_RANGE);
              end else begin
                frame_end = nxt + rem_len;
                phase = mpd_pkg::PH_TLEN_HI;
              end
            end
          end
        end
        mpd_pkg::PH_TLEN_HI: begin
          topic_size = {b, 8'h00};
          phase = mpd_pkg::PH_TLEN_LO;
        end
        mpd_pkg::PH_TLEN_LO: begin
          avail = (frame_end >= nxt) ? frame_end - nxt : 0;
          topic_size = topic_size | b;
          if (topic_size == 0 || topic_size >= topic_cap || topic_size > avail) begin
            abort(mpd_pkg::ST_BAD_TOPIC);
          end else begin
            field_cnt = topic_size;
            phase = mpd_pkg::PH_TOPIC;
          end
        end
        mpd_pkg::PH_TOPIC: begin
          queue_word(mpd_pkg::KIND_TOPIC, b, mpd_pkg::ST_OK, 0, 0);
          if (field_cnt > 0) field_cnt--;
          if (field_cnt == 0) after_topic(nxt);
        end
        mpd_pkg::PH_PKTID: begin
          if (field_cnt > 0) field_cnt--;
          if (field_cnt == 0) start_payload(nxt);
        end
        mpd_pkg::PH_PAYLOAD: begin
          queue_word(mpd_pkg::KIND_PAYLOAD, b, mpd_pkg::ST_OK, 0, 0);
          if (nxt >= frame_end) phase = mpd_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
      if (fin) begin
        if (seen < mpd_pkg::MIN_FRAME_BYTES) st = mpd_pkg::ST_SHORT;
        else if (err == mpd_pkg::ST_NOT_PUBLISH || err == mpd_pkg::ST_BAD_LEN_CODE ||
                 err == mpd_pkg::ST_LEN_RANGE) st = err;
        else if (phase == mpd_pkg::PH_LENGTH) st = mpd_pkg::ST_BAD_LEN_CODE;
        else if (seen < frame_end) st = mpd_pkg::ST_LEN_RANGE;
        else st = err;
        queue_word(mpd_pkg::KIND_VERDICT, 8'h00, st, topic_size,
                   (st == mpd_pkg::ST_OK || st == mpd_pkg::ST_PAYLOAD_LONG) ? field_cnt : 0);
        verdicts[st]++;
        clear_frame();
      end
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        fails++;
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_word(mpd_pkg::res_t got);
      mpd_pkg::res_t want;
      if (expected_words.size() == 0) begin
        fails++;
        $error("unexpected word: kind %0d byte %0d", got.kind, got.byte_value);
        return;
      end
      want = expected_words.pop_front();
      checked++;
      compare("kind", want.kind, got.kind);
      compare("byte_value", want.byte_value, got.byte_value);
      compare("status", want.status, got.status);
      compare("topic_length", want.topic_length, got.topic_length);
      compare("payload_length", want.payload_length, got.payload_length);
      compare("qos_level", want.qos_level, got.qos_level);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           idle_on;
  int                             cycles;
  int                             bytes_sent;
  int                             packets;
  logic [7:0]                     frame_q[$];
  publish_scoreboard              sb;

  mpd_rx_if rx_ch ();
  mpd_tx_if tx_ch ();

  mqtt_publish_deframer_core #(.COUNT_WIDTH(16)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .tx(tx_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    tx_ch.ready <= (idle_on && $urandom_range(99) < 27) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin : watch
    mpd_pkg::res_t got;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) sb.decode_byte(rx_ch.data_byte, rx_ch.last_byte);
      if (tx_ch.valid && tx_ch.ready) begin
        got.kind = mpd_pkg::kind_t'(tx_ch.kind);
        got.byte_value = tx_ch.byte_value;
        got.status = mpd_pkg::status_t'(tx_ch.status);
        got.topic_length = tx_ch.topic_length;
        got.payload_length = tx_ch.payload_length;
        got.qos_level = tx_ch.qos_level;
        got.last = tx_ch.last;
        sb.check_word(got);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 27) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.data_byte <= b;
    rx_ch.last_byte <= fin;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    bytes_sent += frame_q.size();
    packets++;
    frame_q.delete();
  endtask

  // wait until every expected word has come out
  task automatic drain();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_caps(input int unsigned topic_cap, input int unsigned payload_cap);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mpd_pkg::REG_TOPIC_CAP;
    cfg_data <= 16'(topic_cap);
    sb.set_cap(mpd_pkg::REG_TOPIC_CAP, topic_cap);
    @(negedge clk);
    cfg_index <= mpd_pkg::REG_PAYLOAD_CAP;
    cfg_data <= 16'(payload_cap);
    sb.set_cap(mpd_pkg::REG_PAYLOAD_CAP, payload_cap);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_noise(int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endfunction

  // base-128 length, padded with continuation digits up to min_digits
  function automatic void put_length(int unsigned value, int min_digits);
    int         n;
    logic [7:0] d;
    n = 0;
    do begin
      d = 8'(value % 128);
      value = value / 128;
      n++;
      if (value != 0 || n < min_digits) d[7] = 1'b1;
      frame_q.push_back(d);
    end while (value != 0 || n < min_digits);
  endfunction

  function automatic void put_publish(int qos, int unsigned tlen_field, int topic_n,
                                      int payload_n, int rem_adjust, int min_digits);
    int pid_n;
    pid_n = (qos != 0) ? 2 : 0;
    frame_q.push_back({mpd_pkg::TYPE_PUBLISH, 1'($urandom), 2'(qos), 1'($urandom)});
    put_length(2 + topic_n + pid_n + payload_n + rem_adjust, min_digits);
    frame_q.push_back(tlen_field[15:8]);
    frame_q.push_back(tlen_field[7:0]);
    add_noise(topic_n + pid_n + payload_n);
  endfunction

  function automatic void put_random_frame();
    int pick;
    int qos;
    int tmax;
    int topic_n;
    int payload_n;
    int digits;
    pick = $urandom_range(99);
    qos = $urandom_range(3);
    tmax = (sb.topic_cap > 13) ? 12 : ((sb.topic_cap > 1) ? sb.topic_cap - 1 : 1);
    topic_n = $urandom_range(tmax, 1);
    payload_n = $urandom_range(24);
    digits = ($urandom_range(9) == 0) ? $urandom_range(4, 2) : 1;
    if (pick < 87) begin
      put_publish(qos, topic_n, topic_n, payload_n, 0, digits);
      if (pick < 65) begin
        if ($urandom_range(7) == 0) add_noise($urandom_range(3, 1));
      end else if (pick < 77) begin
        repeat ($urandom_range(frame_q.size() - 1, 1)) void'(frame_q.pop_back());
      end else begin
        frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom);
      end
    end else if (pick < 95) begin
      add_noise($urandom_range(8, 1));
    end else begin
      put_publish(qos, $urandom_range(65535), topic_n, payload_n, 0, 1);
    end
  endfunction

  initial begin
    int unsigned tcap;
    int unsigned pcap;
    int          start;
    clk = 1'b0;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.data_byte = 8'h00;
    rx_ch.last_byte = 1'b0;
    tx_ch.ready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mpd_pkg::REG_TOPIC_CAP;
    cfg_data = '0;
    idle_on = 1'b1;
    bytes_sent = 0;
    packets = 0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at reset capacities
    put_publish(0, 3, 3, 4, 0, 1); send_frame();
    put_publish(1, 2, 2, 3, 0, 1); send_frame();
    put_publish(2, 5, 5, 1, 0, 1); send_frame();
    put_publish(3, 1, 1, 2, 0, 1); send_frame();
    frame_q = '{8'h3B}; send_frame();
    frame_q = '{8'h32, 8'h05, 8'h00}; send_frame();
    frame_q = '{8'h20}; add_noise(5); send_frame();
    frame_q = '{8'h30, 8'h01}; add_noise(3); send_frame();
    frame_q = '{8'h30}; put_length(3, 5); add_noise(3); send_frame();
    frame_q = '{8'h30, 8'h80, 8'hFF, 8'h80}; send_frame();
    frame_q = '{8'h30}; put_length(65532, 1); add_noise(2); send_frame();
    frame_q = '{8'h34}; put_length(28'hFFFFFFF, 1); add_noise(2); send_frame();
    put_publish(0, 4, 4, 6, 0, 1); repeat (3) void'(frame_q.pop_back()); send_frame();
    put_publish(0, 0, 0, 5, 0, 1); send_frame();
    put_publish(0, 10, 3, 2, 0, 1); send_frame();
    put_publish(1, 3, 3, 0, -2, 1); send_frame();
    put_publish(2, 2, 2, 3, 0, 1); add_noise(3); send_frame();
    put_publish(1, 4, 4, 4, 0, 4); send_frame();
    put_publish(0, 8, 8, 0, 0, 1); repeat (4) void'(frame_q.pop_back()); send_frame();
    frame_q = '{8'h30, 8'h06, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hFF, 8'h00}; send_frame();
    drain();

    set_caps(96, 1);
    put_publish(0, 2, 2, 0, 0, 1); send_frame();
    put_publish(0, 2, 2, 1, 0, 1); send_frame();
    drain();
    set_caps(1, 65535);
    put_publish(0, 1, 1, 3, 0, 1); send_frame();
    drain();
    set_caps(0, 0);
    put_publish(0, 1, 1, 2, 0, 1); send_frame();
    put_publish(2, 3, 3, 0, 0, 1); send_frame();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin tcap = mpd_pkg::TOPIC_CAP_RESET; pcap = mpd_pkg::PAYLOAD_CAP_RESET; end
        1: begin tcap = 6; pcap = 10; end
        2: begin tcap = 65535; pcap = 65535; end
        3: begin tcap = 2; pcap = 1; end
        default: begin tcap = $urandom_range(128, 2); pcap = $urandom_range(64, 1); end
      endcase
      set_caps(tcap, pcap);
      idle_on = (p != 2);
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES / RANDOM_PHASES) begin
        put_random_frame();
        send_frame();
        if ($urandom_range(11) == 0) drain();
      end
      drain();
    end
    idle_on = 1'b1;

    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d bytes in %0d packets, %0d words checked, %0d cycles",
             bytes_sent, packets, sb.checked, cycles);
    $display("verdicts: ok %0d short %0d type %0d code %0d range %0d topic %0d id %0d size %0d",
             sb.verdicts[mpd_pkg::ST_OK], sb.verdicts[mpd_pkg::ST_SHORT],
             sb.verdicts[mpd_pkg::ST_NOT_PUBLISH], sb.verdicts[mpd_pkg::ST_BAD_LEN_CODE],
             sb.verdicts[mpd_pkg::ST_LEN_RANGE], sb.verdicts[mpd_pkg::ST_BAD_TOPIC],
             sb.verdicts[mpd_pkg::ST_NO_PKTID], sb.verdicts[mpd_pkg::ST_PAYLOAD_LONG]);
    if (sb.fails == 0 && sb.expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_ifs.sv
hw/rtl/mpd_parser.sv
hw/rtl/mpd_out_queue.sv
hw/rtl/mpd_publish_deframer_core_top_placeholder.sv
hw/rtl/mqtt_publish_deframer_core.sv
verif/tb_mqtt_publish_deframer_core.sv
